// ----- hw/rtl/qrs_pkg.sv -----
package qrs_pkg;

    localparam int COEFF_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 34;
    // signed discriminant, |b*b| + |4ac| < 2^33
    localparam int D_BITS     = 35;
    // |d| padded to an even width for the root digit pairs
    localparam int DMAG_BITS  = 34;
    // floor(sqrt(|d| * 2^(2F))) < 2^33
    localparam int ROOT_BITS  = 33;
    localparam int REM_BITS   = ROOT_BITS + 2;
    // -b * 2^F, signed
    localparam int NB_BITS    = COEFF_BITS + FRAC_BITS + 1;
    // |2a|
    localparam int DEN_BITS   = COEFF_BITS + 1;
    // magnitude of a numerator, also the quotient width
    localparam int NUM_BITS   = 34;

    localparam logic [1:0] COUNT_COMPLEX = 2'd0;
    localparam logic [1:0] COUNT_REPEAT  = 2'd1;
    localparam logic [1:0] COUNT_TWO     = 2'd2;

    typedef struct packed {
        logic [1:0]                count;
        logic                      degen;
        logic signed [NB_BITS-1:0] nb;
        logic signed [DEN_BITS:0]  den;
    } sq_side_t;

    typedef struct packed {
        logic [1:0] count;
        logic       degen;
    } dv_side_t;

endpackage

// ----- hw/rtl/qrs_sqrt_pipe.sv -----
module qrs_sqrt_pipe (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [qrs_pkg::DMAG_BITS-1:0]    in_mag,
    input  qrs_pkg::sq_side_t                in_side,
    output logic                             out_valid,
    output logic [qrs_pkg::ROOT_BITS-1:0]    out_root,
    output qrs_pkg::sq_side_t                out_side
);
    import qrs_pkg::*;

    // one root bit per stage, two radicand bits consumed per stage
    logic                 v_reg    [ROOT_BITS];
    logic [DMAG_BITS-1:0] rad_reg  [ROOT_BITS];
    logic [REM_BITS-1:0]  rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS];
    sq_side_t             side_reg [ROOT_BITS];

    for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
        logic                 v_in;
        logic [DMAG_BITS-1:0] rad_in;
        logic [REM_BITS-1:0]  rem_in;
        logic [ROOT_BITS-1:0] root_in;
        sq_side_t             side_in;
        logic [REM_BITS+1:0]  cur;
        logic [REM_BITS+1:0]  trial;
        logic                 take;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_mag;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign cur   = {rem_in, rad_in[DMAG_BITS-1 -: 2]};
        assign trial = {{(REM_BITS-ROOT_BITS){1'b0}}, root_in, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i]  <= rad_in << 2;
                rem_reg[i]  <= take ? REM_BITS'(cur - trial) : cur[REM_BITS-1:0];
                root_reg[i] <= {root_in[ROOT_BITS-2:0], take};
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_BITS-1];
    assign out_root  = root_reg[ROOT_BITS-1];
    assign out_side  = side_reg[ROOT_BITS-1];

endmodule

// ----- hw/rtl/qrs_div_pipe.sv -----
module qrs_div_pipe (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [1:0][qrs_pkg::NUM_BITS-1:0]    in_num,
    input  logic [1:0]                           in_neg,
    input  logic [qrs_pkg::DEN_BITS-1:0]         in_den,
    input  qrs_pkg::dv_side_t                    in_side,
    output logic                                 out_valid,
    output logic [1:0][qrs_pkg::NUM_BITS-1:0]    out_quot,
    output logic [1:0]                           out_neg,
    output qrs_pkg::dv_side_t                    out_side
);
    import qrs_pkg::*;

    // restoring division, one quotient bit per stage, two lanes sharing the divisor
    logic                          v_reg    [NUM_BITS];
    logic [1:0][NUM_BITS-1:0]      nq_reg   [NUM_BITS];
    logic [1:0][DEN_BITS-1:0]      rem_reg  [NUM_BITS];
    logic [DEN_BITS-1:0]           den_reg  [NUM_BITS];
    logic [1:0]                    neg_reg  [NUM_BITS];
    dv_side_t                      side_reg [NUM_BITS];

    for (genvar i = 0; i < NUM_BITS; i++) begin : g_stage
        logic                     v_in;
        logic [1:0][NUM_BITS-1:0] nq_in;
        logic [1:0][DEN_BITS-1:0] rem_in;
        logic [DEN_BITS-1:0]      den_in;
        logic [1:0]               neg_in;
        dv_side_t                 side_in;
        logic [1:0][DEN_BITS:0]   cur;
        logic [1:0]               take;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign nq_in   = in_num;
            assign rem_in  = '0;
            assign den_in  = in_den;
            assign neg_in  = in_neg;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[i-1];
            assign nq_in   = nq_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            assign cur[l]  = {rem_in[l], nq_in[l][NUM_BITS-1]};
            assign take[l] = (cur[l] >= {1'b0, den_in});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[i][l] <= take[l] ? DEN_BITS'(cur[l] - {1'b0, den_in})
                                             : cur[l][DEN_BITS-1:0];
                    nq_reg[i][l]  <= {nq_in[l][NUM_BITS-2:0], take[l]};
                end
                den_reg[i]  <= den_in;
                neg_reg[i]  <= neg_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[NUM_BITS-1];
    assign out_quot  = nq_reg[NUM_BITS-1];
    assign out_neg   = neg_reg[NUM_BITS-1];
    assign out_side  = side_reg[NUM_BITS-1];

endmodule

// ----- hw/rtl/quadratic_root_solver_unit.sv -----
// Quadratic root solver, a*x^2 + b*x + c = 0.
// Request channel: req_valid/req_ready with coeff_square, coeff_linear, coeff_constant.
// Response channel: rsp_valid/rsp_ready with root_count, first_value, second_value
// and degenerate; values are signed with 16 fraction bits, truncated toward zero.
// One response per request, in request order.
// The pipeline has 69 register stages: one product stage, 33 square-root stages
// (one root bit each), 34 divider stages (one quotient bit each, two lanes) and
// the output register.
// Throughput: one transaction per cycle; every stage advances together.
// When rsp_valid is high and rsp_ready is low the whole pipeline holds and
// req_ready drops; nothing is lost or repeated. When the output register is empty
// the pipeline keeps moving and bubbles drain toward it.
// Reset clears every stage valid bit; the data registers are not reset.
// a == 0 sets degenerate and forces both values to zero.
module quadratic_root_solver_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic signed [qrs_pkg::COEFF_BITS-1:0] coeff_square,
    input  logic signed [qrs_pkg::COEFF_BITS-1:0] coeff_linear,
    input  logic signed [qrs_pkg::COEFF_BITS-1:0] coeff_constant,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic [1:0]                            root_count,
    output logic signed [qrs_pkg::OUT_BITS-1:0]   first_value,
    output logic signed [qrs_pkg::OUT_BITS-1:0]   second_value,
    output logic                                  degenerate
);
    import qrs_pkg::*;

    logic en;

    // product stage
    logic                               p_valid_reg;
    logic signed [2*COEFF_BITS-1:0]     bb_reg;
    logic signed [2*COEFF_BITS-1:0]     ac_reg;
    logic signed [COEFF_BITS-1:0]       a_reg;
    logic signed [COEFF_BITS-1:0]       b_reg;

    // discriminant
    logic signed [D_BITS-1:0] d;
    logic [D_BITS-1:0]        d_abs;
    sq_side_t                 sq_side;

    // square root out
    logic                 sq_valid;
    logic [ROOT_BITS-1:0] sq_root;
    sq_side_t             sq_out_side;

    // divider in
    logic signed [D_BITS-1:0] nb_ext;
    logic signed [D_BITS-1:0] s_ext;
    logic signed [D_BITS-1:0] num1;
    logic signed [D_BITS-1:0] num2;
    logic [D_BITS-1:0]        num1_abs;
    logic [D_BITS-1:0]        num2_abs;
    logic [DEN_BITS:0]        den_abs;
    logic [1:0][NUM_BITS-1:0] dv_num;
    logic [1:0]               dv_neg;
    logic                     den_neg;
    dv_side_t                 dv_side;

    // divider out
    logic                     dv_valid;
    logic [1:0][NUM_BITS-1:0] dv_quot;
    logic [1:0]               dv_out_neg;
    dv_side_t                 dv_out_side;

    logic                       out_valid_reg;
    logic [1:0]                 count_reg;
    logic signed [OUT_BITS-1:0] first_reg;
    logic signed [OUT_BITS-1:0] second_reg;
    logic                       degen_reg;
    logic signed [OUT_BITS-1:0] first_next;
    logic signed [OUT_BITS-1:0] second_next;

    assign en        = !out_valid_reg || rsp_ready;
    assign req_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg <= coeff_linear * coeff_linear;
            ac_reg <= coeff_square * coeff_constant;
            a_reg  <= coeff_square;
            b_reg  <= coeff_linear;
        end
    end

    always_comb
    begin
        d     = D_BITS'(bb_reg) - (D_BITS'(ac_reg) <<< 2);
        d_abs = d[D_BITS-1] ? D_BITS'(-d) : D_BITS'(d);
        if (d[D_BITS-1])
            sq_side.count = COUNT_COMPLEX;
        else if (d == '0)
            sq_side.count = COUNT_REPEAT;
        else
            sq_side.count = COUNT_TWO;
        sq_side.degen = (a_reg == '0);
        sq_side.nb    = -$signed({{(NB_BITS-COEFF_BITS-FRAC_BITS){b_reg[COEFF_BITS-1]}},
                                  b_reg, {FRAC_BITS{1'b0}}});
        sq_side.den   = $signed({a_reg[COEFF_BITS-1], a_reg, 1'b0});
    end

    qrs_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .in_mag    (d_abs[DMAG_BITS-1:0]),
        .in_side   (sq_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_out_side)
    );

    always_comb
    begin
        nb_ext  = D_BITS'(sq_out_side.nb);
        s_ext   = $signed({{(D_BITS-ROOT_BITS){1'b0}}, sq_root});
        den_neg = sq_out_side.den[DEN_BITS];
        den_abs = den_neg ? (DEN_BITS+1)'(-sq_out_side.den)
                          : (DEN_BITS+1)'(sq_out_side.den);
        num1 = nb_ext;
        num2 = nb_ext;
        if (sq_out_side.count == COUNT_TWO)
        begin
            num1 = nb_ext + s_ext;
            num2 = nb_ext - s_ext;
        end
        num1_abs = num1[D_BITS-1] ? D_BITS'(-num1) : D_BITS'(num1);
        num2_abs = num2[D_BITS-1] ? D_BITS'(-num2) : D_BITS'(num2);
        dv_num[0] = num1_abs[NUM_BITS-1:0];
        dv_neg[0] = num1[D_BITS-1] ^ den_neg;
        if (sq_out_side.count == COUNT_COMPLEX)
        begin
            // imaginary part is a magnitude
            dv_num[1] = s_ext[NUM_BITS-1:0];
            dv_neg[1] = 1'b0;
        end
        else
        begin
            dv_num[1] = num2_abs[NUM_BITS-1:0];
            dv_neg[1] = num2[D_BITS-1] ^ den_neg;
        end
        dv_side.count = sq_out_side.count;
        dv_side.degen = sq_out_side.degen;
    end

    qrs_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (dv_num),
        .in_neg    (dv_neg),
        .in_den    (den_abs[DEN_BITS-1:0]),
        .in_side   (dv_side),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_neg   (dv_out_neg),
        .out_side  (dv_out_side)
    );

    always_comb
    begin
        first_next  = dv_out_neg[0] ? OUT_BITS'(-$signed(dv_quot[0]))
                                    : $signed(dv_quot[0]);
        second_next = dv_out_neg[1] ? OUT_BITS'(-$signed(dv_quot[1]))
                                    : $signed(dv_quot[1]);
        if (dv_out_side.degen)
        begin
            first_next  = '0;
            second_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg  <= dv_out_side.count;
            degen_reg  <= dv_out_side.degen;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign root_count   = count_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;
    assign degenerate   = degen_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && degenerate |-> first_value == '0 && second_value == '0)
        else $error("degenerate result carries nonzero values");

    a_imag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && root_count == COUNT_COMPLEX |-> !second_value[OUT_BITS-1])
        else $error("imaginary magnitude is negative");

    a_repeat_equal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && root_count == COUNT_REPEAT |-> first_value == second_value)
        else $error("repeated root values differ");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled without a held response");

endmodule
